/* src/pqd_pkg.sv */
// Shared types and constants of the product-quantization distance scan.
// Used by every module under src but pqd_ram; no dependencies of its own.
`default_nettype none
package pqd_pkg;

  localparam int unsigned MAX_SUBSPACES = 16;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned CODES_PER_SUB = 256;
  localparam int unsigned VALUE_W       = 24;
  localparam int unsigned GROUP_SIZE    = 4;
  localparam int unsigned NUM_GROUPS    = MAX_SUBSPACES / GROUP_SIZE;
  localparam int unsigned GROUP_SUM_W   = VALUE_W + 2;
  localparam int unsigned SUM_W         = VALUE_W + 4;
  localparam int unsigned CELL_W        = 16;
  localparam int unsigned OFFSET_W      = 24;
  localparam int unsigned DIST_W        = 32;
  localparam int unsigned IN_TDATA_W    = 208;
  localparam int unsigned OUT_TDATA_W   = 80;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);

  // Item kind carried in tuser
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SCORE = 1'b1
  } pqd_cmd_e;

  // Input beat layout, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]            pad;
    logic [OFFSET_W-1:0]   entry_offset;
    logic [CELL_W-1:0]     cell_id;
    logic                  entry_valid;
    logic [63:0]           codes_high;
    logic [63:0]           codes_low;
    logic [VALUE_W-1:0]    lut_value;
    logic [CODE_W-1:0]     lut_code;
    logic [3:0]            lut_subspace;
  } pqd_in_t;

  // Side information that rides along with the table lookups
  typedef struct packed {
    logic                  entry_valid;
    logic [CELL_W-1:0]     cell_id;
    logic [OFFSET_W-1:0]   offset;
  } pqd_meta_t;

  // One result, cell in the lowest bits
  typedef struct packed {
    logic [DIST_W-1:0]     distance;
    logic [OFFSET_W:0]     result_offset;
    logic [CELL_W:0]       result_cell;
  } pqd_result_t;

  localparam int unsigned RESULT_W = $bits(pqd_result_t);

endpackage
`default_nettype wire

/* src/pqd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module pqd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/pqd_sum_tree.sv */
// Two-stage registered adder tree over the per-subspace table entries.
// Depends on pqd_pkg.
`default_nettype none
module pqd_sum_tree #(
  parameter int unsigned SUBSPACES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire pqd_pkg::pqd_meta_t                meta_i,
  input  wire logic [pqd_pkg::VALUE_W-1:0]       lanes_i [SUBSPACES],
  output logic                                   valid_o,
  output pqd_pkg::pqd_meta_t                     meta_o,
  output logic      [pqd_pkg::SUM_W-1:0]         sum_o
);
  import pqd_pkg::*;

  logic [VALUE_W-1:0]     lane_pad [MAX_SUBSPACES];
  logic [GROUP_SUM_W-1:0] group_d  [NUM_GROUPS];
  logic [GROUP_SUM_W-1:0] group_q  [NUM_GROUPS];
  logic                   valid_a_q;
  pqd_meta_t              meta_a_q;
  logic [SUM_W-1:0]       sum_d;

  // unused subspaces add nothing
  for (genvar i = 0; i < MAX_SUBSPACES; i++) begin : g_pad
    if (i < SUBSPACES) begin : g_used
      assign lane_pad[i] = lanes_i[i];
    end else begin : g_zero
      assign lane_pad[i] = '0;
    end
  end

  // first level: groups of four lanes
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_d[g] = GROUP_SUM_W'(lane_pad[g*GROUP_SIZE])
                 + GROUP_SUM_W'(lane_pad[g*GROUP_SIZE+1])
                 + GROUP_SUM_W'(lane_pad[g*GROUP_SIZE+2])
                 + GROUP_SUM_W'(lane_pad[g*GROUP_SIZE+3]);
    end
  end

  // second level: sum of the group sums
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sum_d = sum_d + SUM_W'(group_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_o   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    group_q  <= group_d;
    meta_a_q <= meta_i;
    meta_o   <= meta_a_q;
    sum_o    <= sum_d;
  end

endmodule
`default_nettype wire

/* src/pqd_out_fifo.sv */
// Result queue between the scan pipeline and the output stream.
// Depends on pqd_pkg.
`default_nettype none
module pqd_out_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire pqd_pkg::pqd_result_t  data_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output pqd_pkg::pqd_result_t       data_o
);
  import pqd_pkg::*;

  pqd_result_t           entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop    ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != FIFO_CNT_W'(FIFO_DEPTH)) || pop)
    else $error("push into full result queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> count_q == $past(count_q) - FIFO_CNT_W'(1))
    else $error("pop did not lower the fill count");

endmodule
`default_nettype wire

/* src/pq_lut_distance_scan.sv */
// Product-quantization distance scan: one beat per cycle, 16 table banks read in parallel.
// Depends on pqd_pkg, pqd_ram, pqd_sum_tree and pqd_out_fifo.
//
// The distance table is split into one 256-entry bank per subspace, so a score beat
// reads all its entries at once and a load beat writes one bank at the accept edge;
// a score that follows a load in the next cycle already sees the new entry. The block
// takes one beat per cycle while the input is not held off. A score beat's result
// passes the bank read at the accept edge, then two adder-tree stages and the result
// queue write, before it can leave. Results wait in an 8-deep queue; the input is held
// off only when eight results are in flight or queued, so a sustained stall on the
// output stops the input after eight score beats. Load beats produce no result. The
// table has no reset: an entry must be loaded before a score reads it.
`default_nettype none
module pq_lut_distance_scan #(
  parameter int unsigned SUBSPACES = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // lut_subspace[3:0], lut_code[11:4], lut_value[35:12], codes_low[99:36],
  // codes_high[163:100], entry_valid[164], cell_id[180:165], entry_offset[204:181]
  input  wire logic [pqd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command[0]
  input  wire logic [0:0]                         s_axis_tuser,
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // result_cell[16:0], result_offset[41:17], distance[73:42]
  output logic      [pqd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // large_distance register write
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pqd_pkg::DIST_W-1:0]         cfg_data_i
);
  import pqd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CODES_PER_SUB);

  pqd_in_t               in_beat;
  pqd_cmd_e              in_cmd;
  logic                  in_accept;
  logic                  score_accept;
  logic                  load_accept;
  logic [2*64-1:0]       codes_all;
  logic [VALUE_W-1:0]    lane_data [SUBSPACES];

  logic                  s1_valid_q;
  pqd_meta_t             s1_meta_q;
  logic                  tree_valid;
  pqd_meta_t             tree_meta;
  logic [SUM_W-1:0]      tree_sum;

  pqd_result_t           result;
  pqd_result_t           out_result;
  logic [DIST_W-1:0]     large_dist_q;
  logic [FIFO_CNT_W-1:0] inflight_q, inflight_d;
  logic                  out_pop;

  assign in_beat      = s_axis_tdata;
  assign in_cmd       = pqd_cmd_e'(s_axis_tuser);
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign score_accept = in_accept && (in_cmd == CMD_SCORE);
  assign load_accept  = in_accept && (in_cmd == CMD_LOAD);
  assign codes_all    = {in_beat.codes_high, in_beat.codes_low};

  // one bank per subspace
  for (genvar s = 0; s < SUBSPACES; s++) begin : g_bank
    pqd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CODES_PER_SUB)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (load_accept && (in_beat.lut_subspace == 4'(s))),
      .waddr_i (ADDR_W'(in_beat.lut_code)),
      .wdata_i (in_beat.lut_value),
      .re_i    (score_accept),
      .raddr_i (ADDR_W'(codes_all[s*CODE_W +: CODE_W])),
      .rdata_o (lane_data[s])
    );
  end

  // side data lined up with the bank read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= score_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_meta_q.entry_valid <= in_beat.entry_valid;
    s1_meta_q.cell_id     <= in_beat.cell_id;
    s1_meta_q.offset      <= in_beat.entry_offset;
  end

  pqd_sum_tree #(
    .SUBSPACES (SUBSPACES)
  ) u_sum_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .meta_i  (s1_meta_q),
    .lanes_i (lane_data),
    .valid_o (tree_valid),
    .meta_o  (tree_meta),
    .sum_o   (tree_sum)
  );

  // padding beats report -1, -1 and the configured large distance
  always_comb begin
    if (tree_meta.entry_valid) begin
      result.result_cell   = {1'b0, tree_meta.cell_id};
      result.result_offset = {1'b0, tree_meta.offset};
      result.distance      = DIST_W'(tree_sum);
    end else begin
      result.result_cell   = '1;
      result.result_offset = '1;
      result.distance      = large_dist_q;
    end
  end

  pqd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tree_valid),
    .data_i  (result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_result)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};
  assign out_pop      = m_axis_tvalid && m_axis_tready;

  // credit count: score beats in the pipeline or the queue
  always_comb begin
    inflight_d = inflight_q;
    if (score_accept && !out_pop) begin
      inflight_d = inflight_q + FIFO_CNT_W'(1);
    end else if (out_pop && !score_accept) begin
      inflight_d = inflight_q - FIFO_CNT_W'(1);
    end
  end

  assign s_axis_tready = (inflight_q < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_dist_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      large_dist_q <= cfg_data_i;
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result shown with no score beat outstanding");

  a_tree_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_valid |-> $past(score_accept, 3))
    else $error("sum without a matching score beat");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for pq_lut_distance_scan: table loads, score and padding beats.
// Depends on pqd_pkg and the pq_lut_distance_scan RTL under src; needs no files at run time.
`default_nettype none
module testbench;
  import pqd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_LIMIT    = 2000;  // cycles without any beat before giving up
  localparam int SETTLE_CYCLES = 16;    // settling time after the last expected result
  localparam int PHASE_ITEMS   = 360;

  localparam logic [CELL_W:0]   PAD_CELL   = '1;
  localparam logic [OFFSET_W:0] PAD_OFFSET = '1;

  // One directed stimulus row; known_res is used only when known is set
  typedef struct packed {
    pqd_cmd_e    cmd;
    pqd_in_t     beat;
    logic        known;
    pqd_result_t known_res;
  } scan_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // lut_subspace, lut_code, lut_value, codes_low, codes_high, entry_valid, cell_id, entry_offset
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // command
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // result_cell, result_offset, distance
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [DIST_W-1:0]      cfg_data_i    = '0;

  // Shadow of the distance table and of the padding distance
  logic [VALUE_W-1:0] lut_shadow [MAX_SUBSPACES][CODES_PER_SUB];
  bit   [CODES_PER_SUB-1:0] loaded_map [MAX_SUBSPACES];
  logic [DIST_W-1:0]  large_dist_q = '1;
  pqd_result_t        dist_expect_q [$];

  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  logic valid_held = 1'b0;

  pq_lut_distance_scan #(
    .SUBSPACES(MAX_SUBSPACES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Expected result of a score beat from the shadow table
  function automatic pqd_result_t predict_score(pqd_in_t b);
    pqd_result_t      r;
    logic [SUM_W-1:0] acc;
    logic [7:0]       code;
    acc = '0;
    if (!b.entry_valid) begin
      r.result_cell   = PAD_CELL;
      r.result_offset = PAD_OFFSET;
      r.distance      = large_dist_q;
    end else begin
      for (int s = 0; s < MAX_SUBSPACES; s++) begin
        code = (s < 8) ? b.codes_low[s*8 +: 8] : b.codes_high[(s-8)*8 +: 8];
        acc += lut_shadow[s][code];
      end
      r.result_cell   = {1'b0, b.cell_id};
      r.result_offset = {1'b0, b.entry_offset};
      r.distance      = {{(DIST_W-SUM_W){1'b0}}, acc};
    end
    return r;
  endfunction

  // Load beat; score fields set to ones since they must be ignored
  function automatic pqd_in_t load_beat(logic [3:0] sub, logic [7:0] code,
                                        logic [VALUE_W-1:0] value);
    pqd_in_t b;
    b = '1;
    b.pad          = '0;
    b.lut_subspace = sub;
    b.lut_code     = code;
    b.lut_value    = value;
    return b;
  endfunction

  // Score beat; load fields set to ones since they must be ignored
  function automatic pqd_in_t score_beat(logic valid, logic [63:0] lo, logic [63:0] hi,
                                         logic [CELL_W-1:0] cell_val,
                                         logic [OFFSET_W-1:0] off);
    pqd_in_t b;
    b = '1;
    b.pad          = '0;
    b.codes_low    = lo;
    b.codes_high   = hi;
    b.entry_valid  = valid;
    b.cell_id      = cell_val;
    b.entry_offset = off;
    return b;
  endfunction

  function automatic pqd_result_t known_result(logic [CELL_W:0] res_cell,
                                               logic [OFFSET_W:0] res_offset,
                                               logic [DIST_W-1:0] res_dist);
    pqd_result_t r;
    r.result_cell   = res_cell;
    r.result_offset = res_offset;
    r.distance      = res_dist;
    return r;
  endfunction

  // Drive one beat, wait for the accept edge, update the shadow, then pace the sender
  task automatic send_beat(input pqd_cmd_e cmd, input pqd_in_t b, input logic known,
                           input pqd_result_t known_res);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_LOAD) begin
      lut_shadow[b.lut_subspace][b.lut_code] = b.lut_value;
      loaded_map[b.lut_subspace][b.lut_code] = 1'b1;
    end else begin
      dist_expect_q.push_back(known ? known_res : predict_score(b));
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // either a long back-to-back stretch or a short burst followed by a gap
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(32, 96);
      end else begin
        gap = $urandom_range(0, 10);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Random beat; valid scores only use codes whose entries were loaded
  task automatic random_beat(output pqd_cmd_e cmd, output pqd_in_t b);
    int          pick;
    int unsigned c;
    b = '0;
    b.lut_subspace = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       b.lut_code = 8'h00;
      1:       b.lut_code = 8'hFF;
      default: b.lut_code = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       b.lut_value = '0;
      1:       b.lut_value = '1;
      2:       b.lut_value = {8'hFF, 16'($urandom)};
      default: b.lut_value = VALUE_W'($urandom);
    endcase
    b.codes_low   = {$urandom, $urandom};
    b.codes_high  = {$urandom, $urandom};
    b.entry_valid = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        b.cell_id = '0;
        b.entry_offset = '0;
      end
      1: begin
        b.cell_id = '1;
        b.entry_offset = '1;
      end
      default: begin
        b.cell_id = CELL_W'($urandom);
        b.entry_offset = OFFSET_W'($urandom);
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      cmd = CMD_LOAD;
    end else if (pick < 85) begin
      cmd = CMD_SCORE;
      b.entry_valid = 1'b1;
      for (int s = 0; s < MAX_SUBSPACES; s++) begin
        c = (pick < 40) ? 255 : $urandom_range(0, 255);
        // walk forward to the next loaded code of this subspace
        for (int k = 0; k < CODES_PER_SUB && !loaded_map[s][c[7:0]]; k++) c++;
        if (s < 8) b.codes_low[s*8 +: 8] = c[7:0];
        else b.codes_high[(s-8)*8 +: 8] = c[7:0];
      end
    end else begin
      cmd = CMD_SCORE;
      b.entry_valid = 1'b0;
    end
  endtask

  // Lower valid, wait for every expected result, then let the pipeline settle
  task automatic drain();
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (dist_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_large_distance(input logic [DIST_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    large_dist_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: ready pattern switches at random among four modes
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= (rx_left % 20 == 0);
      default: m_axis_tready <= rx_left[0];
    endcase
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    pqd_result_t got;
    pqd_result_t want;
    got = m_axis_tdata[RESULT_W-1:0];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dist_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = dist_expect_q.pop_front();
        if (got.result_cell !== want.result_cell) begin
          $display("%0t: result_cell expected %h got %h", $time,
                   want.result_cell, got.result_cell);
          mismatches++;
        end
        if (got.result_offset !== want.result_offset) begin
          $display("%0t: result_offset expected %h got %h", $time,
                   want.result_offset, got.result_offset);
          mismatches++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: distance expected %h got %h", $time, want.distance, got.distance);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin : stimulus
    scan_row_t           dir_rows [$];
    pqd_cmd_e            cmd;
    pqd_in_t             beat;
    logic [DIST_W-1:0]   phase_dist [5];

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Preload code 0 as zero and code 255 as the largest value in every subspace
    for (int s = 0; s < MAX_SUBSPACES; s++) begin
      send_beat(CMD_LOAD, load_beat(4'(s), 8'h00, '0), 1'b0, '0);
      send_beat(CMD_LOAD, load_beat(4'(s), 8'hFF, '1), 1'b0, '0);
    end

    // Directed rows
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b0, '1, '1, '1, '1), 1'b1,
                         known_result(PAD_CELL, PAD_OFFSET, 32'hFFFF_FFFF)});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, '0, '0, '0, '0), 1'b1,
                         known_result('0, '0, '0)});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, '1, '1, '1, '1), 1'b1,
                         known_result(17'h0FFFF, 25'h0FFFFFF, 32'h0FFF_FFF0)});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, 64'hFF00_FF00_FF00_FF00,
                         64'h00FF_00FF_00FF_00FF, 16'h5555, 24'hAAAAAA), 1'b0, '0});
    // load then score on the next beat sees the new entry
    dir_rows.push_back(scan_row_t'{CMD_LOAD, load_beat(4'd0, 8'h00, '1), 1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, '0, '0, 16'h8000, 24'h800000),
                         1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_LOAD, load_beat(4'd15, 8'hFF, '0), 1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, '1, '1, 16'h0001, 24'h000001),
                         1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_LOAD, load_beat(4'd7, 8'h80, 24'h800001), 1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_LOAD, load_beat(4'd8, 8'h01, 24'h000001), 1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, 64'h8000_0000_0000_0000,
                         64'h0000_0000_0000_0001, 16'hFFFE, 24'hFFFFFE), 1'b0, '0});
    // padding ignores its codes
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b0, '0, '0, '0, '0), 1'b1,
                         known_result(PAD_CELL, PAD_OFFSET, 32'hFFFF_FFFF)});
    dir_rows.push_back(scan_row_t'{CMD_LOAD, load_beat(4'd0, 8'h00, '0), 1'b0, '0});
    dir_rows.push_back(scan_row_t'{CMD_SCORE, score_beat(1'b1, '0, '0, 16'h0001, 24'h000001),
                         1'b1, known_result(17'h00001, 25'h0000001, '0)});
    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].beat, dir_rows[i].known, dir_rows[i].known_res);
    drain();

    // Random phases, each with its own padding distance
    phase_dist[0] = '0;
    phase_dist[1] = $urandom;
    phase_dist[2] = '1;
    phase_dist[3] = 32'h0000_0001;
    phase_dist[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      write_large_distance(phase_dist[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_beat(cmd, beat);
        send_beat(cmd, beat, 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0 && dist_expect_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
